// ----- rtl/cbal_pkg.sv -----
// shared types and constants for the cubic bezier arc length unit
`default_nettype none
package cbal_pkg;

  localparam int COORD_W   = 16;
  localparam int T_FRAC    = 24;
  localparam int SEG_W     = 13;
  localparam int K_W       = 12;
  localparam int LEN_W     = 19;
  localparam int ABC_W     = 20;
  localparam int MUL_W     = 25;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int COEF_W    = 48;
  localparam int V_W       = COEF_W + T_FRAC;
  localparam int ACC_W     = V_W + T_FRAC;
  localparam int ROOT_W    = V_W / 2;
  localparam int SUM_W     = ROOT_W + K_W;
  localparam int ROOT_FRAC = 12;
  localparam int QUO_W     = SUM_W - ROOT_FRAC;
  localparam int CNT_W     = 6;

  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(64);
  localparam logic [SEG_W-1:0] SEG_MAX   = SEG_W'(4096);
  localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};

  localparam logic [CNT_W-1:0] COEF_LAST = CNT_W'(12);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);
  localparam logic [2:0]       PH_LAST   = 3'd4;

  typedef enum logic [3:0] {
    MUL_AXAX, MUL_AYAY, MUL_AXBX, MUL_AYBY, MUL_AXCX, MUL_AYCY,
    MUL_BXBX, MUL_BYBY, MUL_BXCX, MUL_BYCY, MUL_CXCX, MUL_CYCY,
    MUL_V0, MUL_V1, MUL_V2
  } mul_sel_t;

  typedef enum logic {
    DIV_RECIP,
    DIV_LEN
  } div_src_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     coef_en;
    logic     horner_init;
    logic     acc_en;
    logic     horner_fin;
    logic [2:0] coef_idx;
    logic     div_start;
    div_src_t div_src;
    logic     div_step;
    logic     base_latch;
    logic     sample_init;
    logic     sqrt_start;
    logic     sqrt_step;
    logic     sum_add;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic last_k;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/cbal_datapath.sv -----
// datapath: coefficients, horner evaluation, square root, divider and sums
`default_nettype none
module cbal_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic        [cbal_pkg::SEG_W-1:0]    cfg_wdata,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p0_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p0_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p1_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p1_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p2_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p2_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p3_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p3_y,
  input  cbal_pkg::cmd_t                       cmd,
  output cbal_pkg::sts_t                       sts,
  output logic        [cbal_pkg::LEN_W-1:0]    arc_length
);

  localparam int CW = cbal_pkg::COORD_W;
  localparam int AW = cbal_pkg::ABC_W;
  localparam int MW = cbal_pkg::MUL_W;
  localparam int PW = cbal_pkg::PROD_W;
  localparam int FW = cbal_pkg::COEF_W;
  localparam int VW = cbal_pkg::V_W;
  localparam int XW = cbal_pkg::ACC_W;
  localparam int TF = cbal_pkg::T_FRAC;
  localparam int RW = cbal_pkg::ROOT_W;
  localparam int SW = cbal_pkg::SUM_W;
  localparam int QW = cbal_pkg::QUO_W;
  localparam int GW = cbal_pkg::SEG_W;
  localparam int KW = cbal_pkg::K_W;
  localparam int LW = cbal_pkg::LEN_W;

  function automatic logic signed [AW-1:0] sx(input logic signed [CW-1:0] p);
    return {{(AW-CW){p[CW-1]}}, p};
  endfunction

  function automatic logic signed [MW-1:0] mx(input logic signed [AW-1:0] p);
    return {{(MW-AW){p[AW-1]}}, p};
  endfunction

  function automatic logic signed [AW-1:0] coef_a(input logic signed [CW-1:0] q0,
      input logic signed [CW-1:0] q1, input logic signed [CW-1:0] q2,
      input logic signed [CW-1:0] q3);
    logic signed [AW-1:0] d;
    d = sx(q1) - sx(q2);
    return (sx(q3) - sx(q0)) + (d <<< 1) + d;
  endfunction

  function automatic logic signed [AW-1:0] coef_b(input logic signed [CW-1:0] q0,
      input logic signed [CW-1:0] q1, input logic signed [CW-1:0] q2);
    logic signed [AW-1:0] e;
    e = sx(q0) - (sx(q1) <<< 1) + sx(q2);
    return (e <<< 1) + e;
  endfunction

  function automatic logic signed [AW-1:0] coef_c(input logic signed [CW-1:0] q0,
      input logic signed [CW-1:0] q1);
    logic signed [AW-1:0] e;
    e = sx(q1) - sx(q0);
    return (e <<< 1) + e;
  endfunction

  logic        [GW-1:0] seg;
  logic        [GW-1:0] div_eff;
  logic        [GW-1:0] div_m1;
  logic signed [AW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [FW-1:0] coef [5];
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  cbal_pkg::mul_sel_t   prod_sel;
  logic signed [FW-1:0] ps, coef_add;
  logic        [2:0]    coef_dst;
  logic signed [XW-1:0] pext;
  logic signed [XW-1:0] acc;
  logic signed [VW-1:0] v;
  logic        [TF-1:0] t;
  logic        [GW-1:0] tr;
  logic        [GW:0]   tr_sum;
  logic        [TF:0]   base_q;
  logic        [GW-1:0] base_r;
  logic        [KW-1:0] k;
  logic        [SW-1:0] sum;
  logic        [VW-1:0] rad;
  logic        [RW:0]   rem;
  logic        [RW+2:0] rem_sh, trial;
  logic        [RW-1:0] root;
  logic        [QW-1:0] dq;
  logic        [GW-1:0] drem;
  logic        [GW:0]   dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= cbal_pkg::SEG_RESET;
    end else if (cfg_we) begin
      seg <= cfg_wdata;
    end
  end

  always_comb begin
    if (seg == '0) begin
      div_eff = GW'(1);
    end else if (seg > cbal_pkg::SEG_MAX) begin
      div_eff = cbal_pkg::SEG_MAX;
    end else begin
      div_eff = seg;
    end
    div_m1 = div_eff - GW'(1);
    sts.last_k = (k == div_m1[KW-1:0]);
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_sel)
      cbal_pkg::MUL_AXAX: begin ma = mx(ax); mb = mx(ax); end
      cbal_pkg::MUL_AYAY: begin ma = mx(ay); mb = mx(ay); end
      cbal_pkg::MUL_AXBX: begin ma = mx(ax); mb = mx(bx); end
      cbal_pkg::MUL_AYBY: begin ma = mx(ay); mb = mx(by); end
      cbal_pkg::MUL_AXCX: begin ma = mx(ax); mb = mx(cx); end
      cbal_pkg::MUL_AYCY: begin ma = mx(ay); mb = mx(cy); end
      cbal_pkg::MUL_BXBX: begin ma = mx(bx); mb = mx(bx); end
      cbal_pkg::MUL_BYBY: begin ma = mx(by); mb = mx(by); end
      cbal_pkg::MUL_BXCX: begin ma = mx(bx); mb = mx(cx); end
      cbal_pkg::MUL_BYCY: begin ma = mx(by); mb = mx(cy); end
      cbal_pkg::MUL_CXCX: begin ma = mx(cx); mb = mx(cx); end
      cbal_pkg::MUL_CYCY: begin ma = mx(cy); mb = mx(cy); end
      cbal_pkg::MUL_V0: begin ma = {1'b0, v[TF-1:0]};      mb = {1'b0, t}; end
      cbal_pkg::MUL_V1: begin ma = {1'b0, v[2*TF-1:TF]};   mb = {1'b0, t}; end
      cbal_pkg::MUL_V2: begin ma = {v[VW-1], v[VW-1:2*TF]}; mb = {1'b0, t}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // scaling of one product into its coefficient
  always_comb begin
    ps = prod[FW-1:0];
    case (prod_sel) inside
      cbal_pkg::MUL_AXAX, cbal_pkg::MUL_AYAY: begin
        coef_dst = 3'd0;
        coef_add = (ps <<< 3) + ps;
      end
      cbal_pkg::MUL_AXBX, cbal_pkg::MUL_AYBY: begin
        coef_dst = 3'd1;
        coef_add = (ps <<< 3) + (ps <<< 2);
      end
      cbal_pkg::MUL_AXCX, cbal_pkg::MUL_AYCY: begin
        coef_dst = 3'd2;
        coef_add = (ps <<< 2) + (ps <<< 1);
      end
      cbal_pkg::MUL_BXBX, cbal_pkg::MUL_BYBY: begin
        coef_dst = 3'd2;
        coef_add = ps <<< 2;
      end
      cbal_pkg::MUL_BXCX, cbal_pkg::MUL_BYCY: begin
        coef_dst = 3'd3;
        coef_add = ps <<< 2;
      end
      default: begin
        coef_dst = 3'd4;
        coef_add = ps;
      end
    endcase
    pext = {{(XW-PW){prod[PW-1]}}, prod};
  end

  always_comb begin
    tr_sum = {1'b0, tr} + {1'b0, base_r};
    rem_sh = {rem, rad[VW-1:VW-2]};
    trial  = {1'b0, root, 2'b01};
    dsh    = {drem, dq[QW-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax <= coef_a(p0_x, p1_x, p2_x, p3_x);
      ay <= coef_a(p0_y, p1_y, p2_y, p3_y);
      bx <= coef_b(p0_x, p1_x, p2_x);
      by <= coef_b(p0_y, p1_y, p2_y);
      cx <= coef_c(p0_x, p1_x);
      cy <= coef_c(p0_y, p1_y);
      for (int i = 0; i < 5; i++) begin
        coef[i] <= '0;
      end
    end else if (cmd.coef_en) begin
      coef[coef_dst] <= coef[coef_dst] + coef_add;
    end

    if (cmd.mul_en) begin
      prod     <= ma * mb;
      prod_sel <= cmd.mul_sel;
    end

    // horner: acc starts at one half so the shift rounds half up
    if (cmd.horner_init || cmd.horner_fin) begin
      acc <= XW'(1) <<< (TF - 1);
    end else if (cmd.acc_en) begin
      case (prod_sel)
        cbal_pkg::MUL_V0: acc <= acc + pext;
        cbal_pkg::MUL_V1: acc <= acc + (pext <<< TF);
        default:          acc <= acc + (pext <<< (2 * TF));
      endcase
    end

    if (cmd.horner_init) begin
      v <= {coef[0], {TF{1'b0}}};
    end else if (cmd.horner_fin) begin
      v <= acc[XW-1:TF] + {coef[cmd.coef_idx], {TF{1'b0}}};
    end

    if (cmd.sample_init) begin
      t   <= '0;
      tr  <= '0;
      k   <= '0;
      sum <= '0;
    end else if (cmd.sum_add) begin
      sum <= sum + {{(SW-RW){1'b0}}, root};
      k   <= k + KW'(1);
      if (tr_sum >= {1'b0, div_eff}) begin
        tr <= GW'(tr_sum - {1'b0, div_eff});
        t  <= t + base_q[TF-1:0] + TF'(1);
      end else begin
        tr <= tr_sum[GW-1:0];
        t  <= t + base_q[TF-1:0];
      end
    end

    // bitwise square root, two radicand bits per step
    if (cmd.sqrt_start) begin
      rad  <= v[VW-1] ? '0 : v;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[VW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= (RW+1)'(rem_sh - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[RW:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end

    // restoring divider by the sample count
    if (cmd.div_start) begin
      dq   <= (cmd.div_src == cbal_pkg::DIV_LEN) ? sum[SW-1:SW-QW] : (QW'(1) << TF);
      drem <= '0;
    end else if (cmd.div_step) begin
      if (dsh >= {1'b0, div_eff}) begin
        drem <= GW'(dsh - {1'b0, div_eff});
        dq   <= {dq[QW-2:0], 1'b1};
      end else begin
        drem <= dsh[GW-1:0];
        dq   <= {dq[QW-2:0], 1'b0};
      end
    end

    if (cmd.base_latch) begin
      base_q <= dq[TF:0];
      base_r <= drem;
    end

    if (cmd.out_load) begin
      arc_length <= (|dq[QW-1:LW]) ? cbal_pkg::LEN_MAX : dq[LW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cbal_ctrl.sv -----
// controller state machine sequencing the arc length datapath
`default_nettype none
module cbal_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cbal_pkg::sts_t sts,
  output cbal_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_COEF, S_DIVA_ST, S_DIVA, S_BASE, S_HINIT, S_HORN,
    S_SQST, S_SQRT, S_SUM, S_DIVB_ST, S_DIVB, S_OUT
  } state_t;

  state_t                     state;
  logic [cbal_pkg::CNT_W-1:0] cnt;
  logic [2:0]                 ph;
  logic [1:0]                 hstep;
  logic                       fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_COEF: begin
        cmd.mul_en  = (cnt != cbal_pkg::COEF_LAST);
        cmd.mul_sel = cbal_pkg::mul_sel_t'(cnt[3:0]);
        cmd.coef_en = (cnt != '0);
      end
      S_DIVA_ST: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = cbal_pkg::DIV_RECIP;
      end
      S_DIVA, S_DIVB: cmd.div_step = 1'b1;
      S_BASE: begin
        cmd.base_latch  = 1'b1;
        cmd.sample_init = 1'b1;
      end
      S_HINIT: cmd.horner_init = 1'b1;
      S_HORN: begin
        unique case (ph)
          3'd0: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = cbal_pkg::MUL_V0;
          end
          3'd1: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = cbal_pkg::MUL_V1; cmd.acc_en = 1'b1;
          end
          3'd2: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = cbal_pkg::MUL_V2; cmd.acc_en = 1'b1;
          end
          3'd3: cmd.acc_en = 1'b1;
          default: begin
            cmd.horner_fin = 1'b1;
            cmd.coef_idx   = {1'b0, hstep} + 3'd1;
          end
        endcase
      end
      S_SQST: cmd.sqrt_start = 1'b1;
      S_SQRT: cmd.sqrt_step = 1'b1;
      S_SUM: cmd.sum_add = 1'b1;
      S_DIVB_ST: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = cbal_pkg::DIV_LEN;
      end
      S_OUT: cmd.out_load = fire;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ph        <= '0;
      hstep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= S_COEF;
          end
        end
        S_COEF: begin
          cnt <= cnt + 1'b1;
          if (cnt == cbal_pkg::COEF_LAST) begin
            state <= S_DIVA_ST;
          end
        end
        S_DIVA_ST: begin
          cnt   <= '0;
          state <= S_DIVA;
        end
        S_DIVA: begin
          cnt <= cnt + 1'b1;
          if (cnt == cbal_pkg::DIV_LAST) begin
            state <= S_BASE;
          end
        end
        S_BASE: state <= S_HINIT;
        S_HINIT: begin
          ph    <= '0;
          hstep <= '0;
          state <= S_HORN;
        end
        S_HORN: begin
          if (ph == cbal_pkg::PH_LAST) begin
            ph <= '0;
            hstep <= hstep + 1'b1;
            if (hstep == 2'd3) begin
              state <= S_SQST;
            end
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_SQST: begin
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == cbal_pkg::SQ_LAST) begin
            state <= S_SUM;
          end
        end
        S_SUM: state <= sts.last_k ? S_DIVB_ST : S_HINIT;
        S_DIVB_ST: begin
          cnt   <= '0;
          state <= S_DIVB;
        end
        S_DIVB: begin
          cnt <= cnt + 1'b1;
          if (cnt == cbal_pkg::DIV_LAST) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_COEF))
    else $error("request accepted without starting coefficient phase");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && fire) |=> out_valid)
    else $error("result load did not raise out_valid");

  a_sqrt_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT && cnt == cbal_pkg::SQ_LAST) |=> (state == S_SUM))
    else $error("square root did not finish after full step count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

// ----- rtl/cubic_bezier_arc_length_unit.sv -----
// top level of the cubic bezier arc length unit
// each sample runs horner over one shared 25x25 multiplier, then the bit-serial square root
// with 36 steps, then a sum step; two 36-step divides frame the sample loop
// one request in flight; the next can be accepted in the cycle after the result is loaded
// synchronous active-high reset returns to idle and sets segment_count to 64
`default_nettype none
module cubic_bezier_arc_length_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic        [cbal_pkg::SEG_W-1:0]    cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p0_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p0_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p1_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p1_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p2_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p2_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p3_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  p3_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [cbal_pkg::LEN_W-1:0]    arc_length
);

  cbal_pkg::cmd_t cmd;
  cbal_pkg::sts_t sts;

  cbal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbal_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .p0_x       (p0_x),
    .p0_y       (p0_y),
    .p1_x       (p1_x),
    .p1_y       (p1_y),
    .p2_x       (p2_x),
    .p2_y       (p2_y),
    .p3_x       (p3_x),
    .p3_y       (p3_y),
    .cmd        (cmd),
    .sts        (sts),
    .arc_length (arc_length)
  );

endmodule
`default_nettype wire
